[sv/mbad_pkg.sv]
// ----------------------------------------------------------------------------
// mbad_pkg
// Shared widths, mirror constants and types of the mirrored bus decoder.
// ----------------------------------------------------------------------------
package mbad_pkg;

  localparam int ADDR_W = 13;
  localparam int BUS_W  = 16;
  localparam int DATA_W = 8;

  localparam int unsigned STORE_DEPTH = 1 << ADDR_W;
  localparam int unsigned PAGE_SHIFT  = 8;

  localparam logic [ADDR_W-1:0] HALF_SPAN  = 13'h0040;
  localparam logic [ADDR_W-1:0] REP_LIMIT  = 13'h0080;

  localparam logic [ADDR_W-1:0] RAM_ZERO   = 13'h1200;
  localparam logic [ADDR_W-1:0] RAM_ONE    = 13'h0080;
  localparam logic [ADDR_W-1:0] RAM_KEEP   = 13'h00FF;
  localparam logic [ADDR_W-1:0] IO_ZERO    = 13'h1004;
  localparam logic [ADDR_W-1:0] IO_ONE     = 13'h0280;
  localparam logic [ADDR_W-1:0] IO_KEEP    = 13'h0283;
  localparam logic [ADDR_W-1:0] TSET_ZERO  = 13'h1000;
  localparam logic [ADDR_W-1:0] TSET_ONE   = 13'h0294;
  localparam logic [ADDR_W-1:0] TSET_KEEP  = 13'h029F;
  localparam logic [ADDR_W-1:0] TRD_ZERO   = 13'h1001;
  localparam logic [ADDR_W-1:0] TRD_ONE    = 13'h0284;
  localparam logic [ADDR_W-1:0] TRD_KEEP   = 13'h028C;
  localparam logic [ADDR_W-1:0] FLAG_ZERO  = 13'h1000;
  localparam logic [ADDR_W-1:0] FLAG_ONE   = 13'h0285;
  localparam logic [ADDR_W-1:0] FLAG_ADDR  = 13'h0285;
  localparam logic [ADDR_W-1:0] EDGE_ZERO  = 13'h1010;
  localparam logic [ADDR_W-1:0] EDGE_ONE   = 13'h0284;
  localparam logic [ADDR_W-1:0] EDGE_KEEP  = 13'h0287;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] addr;
  } fold_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

endpackage

[sv/mirrored_bus_address_decoder.sv]
// ----------------------------------------------------------------------------
// mirrored_bus_address_decoder
// Folds bus accesses onto an 8192-byte store; low writes are replicated.
// ----------------------------------------------------------------------------
// read: registered store data moves to the output register in S_RD once free
// plain write: S_FIN loads zero to the output register; new input only in S_IDLE
// replicated write: one store write per cycle in S_REP for 2*MIRROR_PAGES copies
// a finished result waits in the output register while the next is taken
// synchronous active-low reset clears control only; store contents undefined
module mirrored_bus_address_decoder
  import mbad_pkg::*;
#(
  parameter int MIRROR_PAGES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [BUS_W-1:0]  in_address,
  input  logic [DATA_W-1:0] in_write_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_read_data
);

  localparam int REP_COUNT = 2 * MIRROR_PAGES;
  localparam int CNT_W     = (REP_COUNT > 1) ? $clog2(REP_COUNT) : 1;

  typedef enum logic [1:0] {S_IDLE, S_RD, S_REP, S_FIN} state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [ADDR_W-1:0] a_r;
  logic [DATA_W-1:0] data_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;

  logic [ADDR_W-1:0] in_a;
  fold_t             fold;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;
  logic              in_fire;
  logic              out_free;
  logic              rep_hit;
  logic              rep_last;
  logic [ADDR_W-1:0] rep_addr;

  assign in_a     = in_address[ADDR_W-1:0];
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign rep_hit  = !fold.hit && (in_a < REP_LIMIT);
  assign rep_last = (cnt_r == CNT_W'(REP_COUNT - 1));

  assign rep_addr = (ADDR_W'(cnt_r >> 1) << PAGE_SHIFT)
                  | (cnt_r[0] ? (a_r ^ HALF_SPAN) : a_r);

  mbad_fold u_fold (
    .addr (in_a),
    .fold (fold)
  );

  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.re    = 1'b0;
    mem_req.addr  = fold.addr;
    mem_req.wdata = in_write_data;
    if (in_fire) begin
      if (in_opcode == OP_READ) begin
        mem_req.re = 1'b1;
      end else if (!rep_hit) begin
        mem_req.we = 1'b1;
      end
    end else if (state_r == S_REP) begin
      mem_req.we    = 1'b1;
      mem_req.addr  = rep_addr;
      mem_req.wdata = data_r;
    end
  end

  mbad_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_RD && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            a_r    <= in_a;
            data_r <= in_write_data;
            cnt_r  <= '0;
            if (in_opcode == OP_READ) begin
              state_r <= S_RD;
            end else if (rep_hit) begin
              state_r <= S_REP;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_RD: begin
          if (out_free) begin
            out_data_r  <= mem_rdata;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_REP: begin
          cnt_r <= cnt_r + 1'b1;
          if (rep_last) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_data_r  <= '0;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

`ifndef SYNTH
  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.we && mem_req.re))
    else $error("store read and write in the same cycle");

  a_rep_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REP && rep_last) |=> (state_r == S_FIN))
    else $error("replicated write did not finish after its last entry");

  a_rep_low: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REP) |-> (a_r < REP_LIMIT))
    else $error("replicated write outside the low region");

  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (out_valid_r && out_data_r == '0))
    else $error("write transaction returned nonzero data");
`endif

endmodule

[sv/mbad_fold.sv]
// ----------------------------------------------------------------------------
// mbad_fold
// Priority chain of mask tests that folds mirrors onto canonical entries.
// ----------------------------------------------------------------------------
module mbad_fold
  import mbad_pkg::*;
(
  input  logic [ADDR_W-1:0] addr,
  output fold_t             fold
);

  always_comb begin
    fold.hit  = 1'b1;
    fold.addr = addr;
    if ((addr & RAM_ZERO) == '0 && (addr & RAM_ONE) == RAM_ONE) begin
      fold.addr = addr & RAM_KEEP;
    end else if ((addr & IO_ZERO) == '0 && (addr & IO_ONE) == IO_ONE) begin
      fold.addr = addr & IO_KEEP;
    end else if ((addr & TSET_ZERO) == '0 && (addr & TSET_ONE) == TSET_ONE) begin
      fold.addr = addr & TSET_KEEP;
    end else if ((addr & TRD_ZERO) == '0 && (addr & TRD_ONE) == TRD_ONE) begin
      fold.addr = addr & TRD_KEEP;
    end else if ((addr & FLAG_ZERO) == '0 && (addr & FLAG_ONE) == FLAG_ONE) begin
      fold.addr = FLAG_ADDR;
    end else if ((addr & EDGE_ZERO) == '0 && (addr & EDGE_ONE) == EDGE_ONE) begin
      fold.addr = addr & EDGE_KEEP;
    end else begin
      fold.hit  = 1'b0;
    end
  end

endmodule

[sv/mbad_store.sv]
// ----------------------------------------------------------------------------
// mbad_store
// Single-port byte store with registered read data.
// ----------------------------------------------------------------------------
module mbad_store
  import mbad_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [STORE_DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule
